// ===== rtl/core/lpm_pkg.sv =====
// Shared types, constants and helper functions of the IPv4 route table.
package lpm_pkg;

  localparam int unsigned TableEntriesDef = 1024;
  localparam int unsigned IfaceCountDef   = 256;
  localparam int unsigned AddrW           = 32;
  localparam int unsigned LenW            = 6;
  localparam logic [AddrW-1:0] AddrMsb    = 32'h8000_0000;

  localparam logic ActInsert = 1'b0;
  localparam logic ActLookup = 1'b1;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusRefused = 2'd1,
    StatusNoRoute = 2'd2
  } lpm_status_e;

  typedef struct packed {
    logic               action;
    logic [31:0]        route_prefix;
    logic [31:0]        route_mask;
    logic [31:0]        next_hop;
    logic signed [15:0] route_priority;
    logic [7:0]         out_iface;
    logic [7:0]         out_device;
    logic [31:0]        dest_addr;
    logic               pref_valid;
    logic [7:0]         pref_device;
  } lpm_req_t;

  typedef struct packed {
    lpm_status_e status;
    logic [31:0] hop_addr;
    logic [7:0]  hop_iface;
    logic [5:0]  matched_len;
  } lpm_rsp_t;

  typedef struct packed {
    logic [31:0]        prefix;
    logic [5:0]         len;
    logic [31:0]        gateway;
    logic signed [15:0] prio;
    logic [7:0]         iface;
    logic [7:0]         device;
  } lpm_entry_t;

  localparam int unsigned EntryW = $bits(lpm_entry_t);

  // Priority encoder on the first zero bit from the MSB down; an all-ones mask gives 32.
  function automatic logic [LenW-1:0] leading_ones(input logic [AddrW-1:0] m);
    logic [LenW-1:0] n;
    n = LenW'(AddrW);
    for (int i = 0; i < AddrW; i++) begin
      if (!m[i]) begin
        n = LenW'(AddrW - 1 - i);
      end
    end
    return n;
  endfunction

  function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
    logic [AddrW-1:0] m;
    if (len >= LenW'(AddrW)) begin
      m = '1;
    end else begin
      m = ~({AddrW{1'b1}} >> len);
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/lpm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module lpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/core/ipv4_lpm_route_table_unit.sv =====
// IPv4 longest-prefix-match route table: route store in one RAM, lookup by linear scan.
// Insert: result strobe in the cycle after start; busy stays low, so inserts may follow every cycle.
// Lookup: busy in Scan, Drain and Fin; result strobe registered from Fin, or in the cycle after
// start if the table is empty; the single RAM read port scans one route per cycle.
// Reset clears the route count and control state; the route RAM itself is not cleared.
// Results cannot be stalled: each is shown for one cycle with done_o high.
module ipv4_lpm_route_table_unit #(
  parameter int unsigned TABLE_ENTRIES = lpm_pkg::TableEntriesDef,
  parameter int unsigned IFACE_COUNT   = lpm_pkg::IfaceCountDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  lpm_pkg::lpm_req_t req_i,
  output logic              done_o,
  output lpm_pkg::lpm_rsp_t rsp_o
);
  import lpm_pkg::*;

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            rd_vld_q, rd_vld_d;
  logic            found_q, found_d;
  lpm_entry_t      best_q, best_d;
  logic [31:0]     dst_q, dst_d;
  logic            pv_q, pv_d;
  logic [7:0]      pdev_q, pdev_d;
  logic            done_q, done_d;
  lpm_rsp_t        rsp_q, rsp_d;

  logic       accept;
  logic       ins_ok;
  logic       ram_we;
  logic       ram_re;
  lpm_entry_t wr_entry;
  logic [EntryW-1:0] ram_rdata;
  lpm_entry_t rd_entry;
  logic       match;
  logic       take;
  logic       last_idx;

  assign accept   = start_i && !busy_o;
  assign ins_ok   = (cnt_q != CntW'(TABLE_ENTRIES)) && ({1'b0, req_i.out_iface} < 9'(IFACE_COUNT));
  assign ram_we   = accept && (req_i.action == ActInsert) && ins_ok;
  assign ram_re   = (state_q == StScan);
  assign last_idx = (CntW'(idx_q) + CntW'(1)) == cnt_q;

  always_comb begin
    wr_entry.prefix  = req_i.route_prefix & req_i.route_mask;
    wr_entry.len     = leading_ones(req_i.route_mask);
    wr_entry.gateway = req_i.next_hop;
    wr_entry.prio    = req_i.route_priority;
    wr_entry.iface   = req_i.out_iface;
    wr_entry.device  = req_i.out_device;
  end

  lpm_ram #(
    .Width(EntryW),
    .Depth(TABLE_ENTRIES),
    .AddrW(IdxW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(cnt_q[IdxW-1:0]),
    .wdata_i(wr_entry),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign rd_entry = lpm_entry_t'(ram_rdata);
  assign match    = (dst_q & len_mask(rd_entry.len)) == rd_entry.prefix;

  // Longer prefix first, then higher priority, then the preferred device over earlier order.
  always_comb begin
    if (!found_q) begin
      take = match;
    end else if (rd_entry.len != best_q.len) begin
      take = match && (rd_entry.len > best_q.len);
    end else if (rd_entry.prio != best_q.prio) begin
      take = match && (rd_entry.prio > best_q.prio);
    end else begin
      take = match && pv_q && (rd_entry.device == pdev_q) && (best_q.device != pdev_q);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    rd_vld_d = 1'b0;
    found_d  = found_q;
    best_d   = best_q;
    dst_d    = dst_q;
    pv_d     = pv_q;
    pdev_d   = pdev_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;

    if (rd_vld_q && take) begin
      found_d = 1'b1;
      best_d  = rd_entry;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (req_i.action == ActInsert) begin
            done_d            = 1'b1;
            rsp_d.status      = ins_ok ? StatusOk : StatusRefused;
            rsp_d.hop_addr    = '0;
            rsp_d.hop_iface   = '0;
            rsp_d.matched_len = '0;
            if (ins_ok) begin
              cnt_d = cnt_q + CntW'(1);
            end
          end else if (cnt_q == '0) begin
            done_d            = 1'b1;
            rsp_d.status      = StatusNoRoute;
            rsp_d.hop_addr    = '0;
            rsp_d.hop_iface   = '0;
            rsp_d.matched_len = '0;
          end else begin
            dst_d   = req_i.dest_addr;
            pv_d    = req_i.pref_valid;
            pdev_d  = req_i.pref_device;
            found_d = 1'b0;
            idx_d   = '0;
            state_d = StScan;
          end
        end
      end
      StScan: begin
        rd_vld_d = 1'b1;
        if (last_idx) begin
          state_d = StDrain;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StDrain: begin
        state_d = StFin;
      end
      StFin: begin
        done_d  = 1'b1;
        state_d = StIdle;
        if (found_q) begin
          rsp_d.status      = StatusOk;
          rsp_d.hop_addr    = (best_q.gateway != '0) ? best_q.gateway : dst_q;
          rsp_d.hop_iface   = best_q.iface;
          rsp_d.matched_len = best_q.len;
        end else begin
          rsp_d.status      = StatusNoRoute;
          rsp_d.hop_addr    = '0;
          rsp_d.hop_iface   = '0;
          rsp_d.matched_len = '0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      cnt_q    <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_vld_d;
      found_q  <= found_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    dst_q  <= dst_d;
    pv_q   <= pv_d;
    pdev_q <= pdev_d;
    rsp_q  <= rsp_d;
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TABLE_ENTRIES))
    else $error("route count exceeds table size");

  a_insert_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action == ActInsert) |=> done_o)
    else $error("insert transaction gave no result");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == StIdle))
    else $error("route RAM written during a scan");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result shown while still busy");

  a_lookup_scans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.action == ActLookup && cnt_q != '0) |=> (busy_o && !done_o))
    else $error("lookup transaction did not start a scan");
`endif

endmodule

// ===== tb/lpm_route_checker.sv =====
// Route table checker: keeps its own route store, predicts each response and compares it.
`timescale 1ns / 1ps
module lpm_route_checker
  import lpm_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef,
  parameter int unsigned IFACE_COUNT   = IfaceCountDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  lpm_req_t req_i,
  input  logic     done_i,
  input  lpm_rsp_t rsp_i,
  output int       pending_o,
  output int       errors_o
);

  logic [31:0] rt_prefix  [TABLE_ENTRIES];
  int          rt_len     [TABLE_ENTRIES];
  logic [31:0] rt_gateway [TABLE_ENTRIES];
  shortint     rt_prio    [TABLE_ENTRIES];
  logic [7:0]  rt_iface   [TABLE_ENTRIES];
  logic [7:0]  rt_device  [TABLE_ENTRIES];
  int          route_count = 0;

  lpm_rsp_t expected_rsp_q[$];
  lpm_rsp_t oldest;
  int       pending_count = 0;
  int       fail_count = 0;

  assign pending_o = pending_count;
  assign errors_o  = fail_count;

  function automatic logic [31:0] prefix_mask(input int len);
    return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic int mask_length(input logic [31:0] m);
    int n;
    n = 0;
    while (n < 32 && m[31-n]) n++;
    return n;
  endfunction

  // Applies one request to the route store and returns the response it should produce.
  function automatic lpm_rsp_t forward_result(input lpm_req_t rq);
    lpm_rsp_t res;
    int       best;
    bit       take;
    res = '0;
    res.status = StatusOk;
    if (rq.action == ActInsert) begin
      if (route_count >= TABLE_ENTRIES || rq.out_iface >= IFACE_COUNT) begin
        res.status = StatusRefused;
      end else begin
        rt_prefix[route_count]  = rq.route_prefix & rq.route_mask;
        rt_len[route_count]     = mask_length(rq.route_mask);
        rt_gateway[route_count] = rq.next_hop;
        rt_prio[route_count]    = rq.route_priority;
        rt_iface[route_count]   = rq.out_iface;
        rt_device[route_count]  = rq.out_device;
        route_count++;
      end
    end else begin
      best = -1;
      for (int i = 0; i < route_count; i++) begin
        if ((rq.dest_addr & prefix_mask(rt_len[i])) != rt_prefix[i]) continue;
        if (best < 0) begin
          take = 1'b1;
        end else if (rt_len[i] != rt_len[best]) begin
          take = rt_len[i] > rt_len[best];
        end else if (rt_prio[i] != rt_prio[best]) begin
          take = rt_prio[i] > rt_prio[best];
        end else begin
          // Equal priority: only a route on the preferred device displaces an earlier one.
          take = rq.pref_valid && rt_device[i] == rq.pref_device &&
                 rt_device[best] != rq.pref_device;
        end
        if (take) best = i;
      end
      if (best < 0) begin
        res.status = StatusNoRoute;
      end else begin
        res.hop_addr    = (rt_gateway[best] != 32'h0) ? rt_gateway[best] : rq.dest_addr;
        res.hop_iface   = rt_iface[best];
        res.matched_len = 6'(rt_len[best]);
      end
    end
    return res;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ns: route check: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      route_count = 0;
      expected_rsp_q.delete();
    end else begin
      if (done_i) begin
        if (expected_rsp_q.size() == 0) begin
          report_error($sformatf("response %h with no transaction outstanding", rsp_i));
        end else begin
          oldest = expected_rsp_q.pop_front();
          if (rsp_i.status !== oldest.status)
            report_error($sformatf("status got %0d, expected %0d", rsp_i.status, oldest.status));
          if (rsp_i.hop_addr !== oldest.hop_addr)
            report_error($sformatf("hop_addr got %h, expected %h",
                                   rsp_i.hop_addr, oldest.hop_addr));
          if (rsp_i.hop_iface !== oldest.hop_iface)
            report_error($sformatf("hop_iface got %0d, expected %0d",
                                   rsp_i.hop_iface, oldest.hop_iface));
          if (rsp_i.matched_len !== oldest.matched_len)
            report_error($sformatf("matched_len got %0d, expected %0d",
                                   rsp_i.matched_len, oldest.matched_len));
        end
      end
      if (start_i && !busy_i) expected_rsp_q.push_back(forward_result(req_i));
    end
    pending_count = expected_rsp_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Route table testbench top: clock, reset, request stimulus, watchdog and the final verdict.
`timescale 1ns / 1ps
module testbench;
  import lpm_pkg::*;

  localparam int unsigned TableDepth = TableEntriesDef;
  localparam int unsigned IfaceCount = IfaceCountDef;
  localparam int StallLimit   = 5000;
  localparam int RandomBlocks = 11;
  localparam int BlockItems   = 50;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  lpm_req_t req = '0;
  logic     done;
  lpm_rsp_t rsp;
  int       mismatch_total;
  int       awaiting;
  int       quiet_cycles = 0;
  int       routes_stored = 0;
  bit       no_gaps = 1'b0;

  // Networks already handed to the table, so that most lookups can be aimed at a route.
  logic [31:0] known_net[$];
  int          known_len[$];

  always #2 clk = ~clk;

  ipv4_lpm_route_table_unit #(
    .TABLE_ENTRIES(TableDepth),
    .IFACE_COUNT  (IfaceCount)
  ) u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .start_i(start),
    .busy_o (busy),
    .req_i  (req),
    .done_o (done),
    .rsp_o  (rsp)
  );

  lpm_route_checker #(
    .TABLE_ENTRIES(TableDepth),
    .IFACE_COUNT  (IfaceCount)
  ) u_checker (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start_i  (start),
    .busy_i   (busy),
    .req_i    (req),
    .done_i   (done),
    .rsp_i    (rsp),
    .pending_o(awaiting),
    .errors_o (mismatch_total)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [31:0] net_mask(input int len);
    return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
  endfunction

  function automatic logic [7:0] pick_device();
    return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  // Fields that the operation ignores still carry random values.
  function automatic lpm_req_t noise_request();
    lpm_req_t r;
    r.action         = 1'($urandom);
    r.route_prefix   = $urandom;
    r.route_mask     = $urandom;
    r.next_hop       = $urandom;
    r.route_priority = 16'($urandom);
    r.out_iface      = 8'($urandom);
    r.out_device     = 8'($urandom);
    r.dest_addr      = $urandom;
    r.pref_valid     = 1'($urandom);
    r.pref_device    = 8'($urandom);
    return r;
  endfunction

  task automatic send(input lpm_req_t r);
    @(negedge clk);
    req   <= r;
    start <= 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic send_insert(input logic [31:0] prefix, input logic [31:0] mask,
                             input logic [31:0] gw, input logic signed [15:0] prio,
                             input logic [7:0] iface, input logic [7:0] dev, input int len);
    lpm_req_t r;
    r = noise_request();
    r.action         = ActInsert;
    r.route_prefix   = prefix;
    r.route_mask     = mask;
    r.next_hop       = gw;
    r.route_priority = prio;
    r.out_iface      = iface;
    r.out_device     = dev;
    send(r);
    if (routes_stored < TableDepth) begin
      routes_stored++;
      known_net.push_back(prefix & mask);
      known_len.push_back(len);
    end
  endtask

  task automatic send_lookup(input logic [31:0] dst, input logic pv, input logic [7:0] pdev);
    lpm_req_t r;
    r = noise_request();
    r.action      = ActLookup;
    r.dest_addr   = dst;
    r.pref_valid  = pv;
    r.pref_device = pdev;
    send(r);
  endtask

  task automatic idle_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 60);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic random_insert();
    int                 len;
    int                 idx;
    int                 sel;
    logic [31:0]        prefix;
    logic [31:0]        mask;
    logic [31:0]        extra;
    logic [31:0]        gw;
    logic signed [15:0] prio;
    sel = $urandom_range(0, 99);
    if (known_net.size() != 0 && sel < 50) begin
      // Same network for ties, or a longer one nested inside it.
      idx    = $urandom_range(0, known_net.size() - 1);
      len    = (sel < 25) ? known_len[idx] : $urandom_range(known_len[idx], 32);
      prefix = known_net[idx] | ($urandom & ~net_mask(known_len[idx]));
    end else begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32) : $urandom_range(8, 28);
      prefix = $urandom;
    end
    mask = net_mask(len);
    sel  = $urandom_range(0, 19);
    if (sel == 0) begin
      mask = $urandom;
    end else if (sel < 4) begin
      // A mask with stray ones below its leading run; clearing those prefix bits lets it match.
      extra = $urandom & ~net_mask(len);
      mask  = mask | extra;
      if ($urandom_range(0, 1) == 1) prefix = prefix & ~extra;
    end
    gw  = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom;
    sel = $urandom_range(0, 19);
    if (sel < 12) prio = 16'(int'($urandom_range(0, 2)) - 1);
    else if (sel < 14) prio = 16'sh7FFF;
    else if (sel < 15) prio = 16'sh8000;
    else prio = 16'($urandom);
    send_insert(prefix, mask, gw, prio, 8'($urandom), pick_device(), len);
  endtask

  task automatic random_lookup();
    logic [31:0] dst;
    int          idx;
    int          sel;
    sel = $urandom_range(0, 99);
    if (known_net.size() != 0 && sel < 75) begin
      idx = $urandom_range(0, known_net.size() - 1);
      dst = known_net[idx] | ($urandom & ~net_mask(known_len[idx]));
    end else if (sel < 80) begin
      dst = 32'h0;
    end else if (sel < 85) begin
      dst = 32'hFFFF_FFFF;
    end else begin
      dst = $urandom;
    end
    send_lookup(dst, 1'($urandom), pick_device());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty table, then a default route and a host route at the opposite length extreme.
    send_lookup(32'hFFFF_FFFF, 1'b1, 8'd0);
    send_insert(32'h1234_5678, 32'h0, 32'h0A00_0001, 16'sd0, 8'd0, 8'd0, 0);
    send_lookup(32'h0, 1'b0, 8'd0);
    send_insert(32'hC0A8_0101, 32'hFFFF_FFFF, 32'h0, 16'sh7FFF, 8'd255, 8'd255, 32);
    send_lookup(32'hC0A8_0101, 1'b0, 8'd255);
    send_lookup(32'hFFFF_FFFF, 1'b0, 8'd0);

    // Two routes of equal length and priority on different devices, then a stronger one.
    send_insert(32'h0A11_2233, 32'hFF00_0000, 32'hFFFF_FFFF, 16'sh8000, 8'd7, 8'd1, 8);
    send_insert(32'h0A00_0000, 32'hFF00_0000, 32'h0B00_0002, 16'sh8000, 8'd8, 8'd2, 8);
    send_lookup(32'h0A01_0203, 1'b0, 8'd2);
    send_lookup(32'h0A01_0203, 1'b1, 8'd2);
    send_lookup(32'h0A01_0203, 1'b1, 8'd1);
    send_insert(32'h0A00_0000, 32'hFF00_0000, 32'h0, 16'sd5, 8'd9, 8'd3, 8);
    send_lookup(32'h0AFE_DCBA, 1'b1, 8'd2);

    // Masks that are not contiguous: one can never match, the other can.
    send_insert(32'hAC10_FFFF, 32'hFFF0_00FF, 32'h0C00_0003, 16'sd1, 8'd10, 8'd4, 12);
    send_lookup(32'hAC10_00FF, 1'b0, 8'd0);
    send_insert(32'hAC20_0000, 32'hFFF0_FF00, 32'h0D00_0004, 16'sd1, 8'd11, 8'd4, 12);
    send_lookup(32'hAC2A_BCDE, 1'b0, 8'd0);

    // A mask without a leading one yields a second route of length zero.
    send_insert(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'sd0, 8'd12, 8'd9, 0);
    send_lookup(32'h0102_0304, 1'b1, 8'd9);
    send_lookup(32'h0102_0304, 1'b0, 8'd9);
    send_lookup(32'h0, 1'b1, 8'd0);
    drain();

    for (int blk = 0; blk < RandomBlocks; blk++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < BlockItems; k++) begin
        if ($urandom_range(0, 9) < 4) random_insert();
        else random_lookup();
        idle_gap();
      end
      if (blk == RandomBlocks / 2 || $urandom_range(0, 2) == 0) drain();
    end

    // A short tail of alternating inserts and lookups with random gaps.
    no_gaps = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (k % 2 == 0) random_insert();
      else random_lookup();
      idle_gap();
    end

    drain();
    repeat (8) @(posedge clk);
    if (mismatch_total == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
